// ----- design/sitrt_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and codes for the signed integer to radix text block.
package sitrt_pkg;

  localparam int MaxSymbols = 64;
  localparam int WordCount  = 8;
  localparam int CfgIdxW    = 8;
  localparam int CfgDataW   = 64;
  localparam int SymbolW    = 8;
  localparam int ValueW     = 32;
  localparam int WordIdxW   = $clog2(WordCount);
  localparam int ByteIdxW   = $clog2(WordCount * 8);
  localparam int RadixW     = $clog2(MaxSymbols + 1);
  localparam int PartW      = RadixW + 1;
  localparam int DigIdxW    = $clog2(ValueW);
  localparam int DigitCntW  = $clog2(ValueW + 1);
  localparam int StepCntW   = $clog2(ValueW);

  localparam logic [SymbolW-1:0] ChSpace = 8'd32;
  localparam logic [SymbolW-1:0] ChPlus  = 8'd43;
  localparam logic [SymbolW-1:0] ChMinus = 8'd45;
  localparam logic [SymbolW-1:0] ChDel   = 8'd127;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RECIP_GO,
    ST_RECIP_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef enum logic {
    OP_RECIP,
    OP_DIGIT
  } div_op_t;

  typedef struct packed {
    logic    start;
    div_op_t op;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- design/sitrt_alpha.sv -----
`timescale 1ns / 1ps
// Alphabet register file with a single byte read port.
module sitrt_alpha import sitrt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic [ByteIdxW-1:0] rd_index,
  output logic [SymbolW-1:0]  rd_byte,
  output logic                cfg_hit
);

  logic [CfgDataW-1:0] words [WordCount];
  logic [WordIdxW-1:0] rd_word;
  logic [2:0]          rd_lane;

  assign cfg_hit = cfg_write && (cfg_index < CfgIdxW'(WordCount));
  assign rd_word = rd_index[ByteIdxW-1:3];
  assign rd_lane = rd_index[2:0];
  assign rd_byte = words[rd_word][rd_lane*8 +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WordCount; i++) begin
        words[i] <= '0;
      end
    end else if (cfg_hit) begin
      words[cfg_index[WordIdxW-1:0]] <= cfg_data;
    end
  end

endmodule

// ----- design/sitrt_divu.sv -----
`timescale 1ns / 1ps
// Shared divide unit: bit-serial reciprocal of the radix, then digit steps (multiply, estimate, correct).
module sitrt_divu import sitrt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  div_req_t            req,
  input  logic [RadixW-1:0]   radix,
  input  logic [ValueW-1:0]   mag,
  output div_stat_t           stat,
  output logic [ValueW-1:0]   quot,
  output logic [ByteIdxW-1:0] rem
);

  logic                        busy;
  logic                        done;
  div_op_t                     op;
  logic [StepCntW-1:0]         cnt;
  logic [ValueW-1:0]           dvd;
  logic [ValueW-1:0]           quo;
  logic [ValueW-1:0]           recip;
  logic [2*ValueW-1:0]         prod;
  logic [PartW-1:0]            part;
  logic [PartW-1:0]            shifted;
  logic                        fits;
  logic [ValueW-1:0]           qest;
  logic [ValueW+RadixW-1:0]    qr_full;
  logic [ValueW-1:0]           diff;

  assign shifted = {part[PartW-2:0], dvd[ValueW-1]};
  assign fits    = shifted >= PartW'(radix);
  assign qest    = prod[2*ValueW-1:ValueW];
  assign qr_full = qest * radix;
  assign diff    = dvd - qr_full[ValueW-1:0];

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = quo;
  assign rem       = ByteIdxW'(part);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        op   <= req.op;
        cnt  <= '0;
        dvd  <= (req.op == OP_RECIP) ? '1 : mag;
        part <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        unique case (op)
          OP_RECIP: begin
            part <= fits ? shifted - PartW'(radix) : shifted;
            quo  <= {quo[ValueW-2:0], fits};
            dvd  <= dvd << 1;
            if (cnt == StepCntW'(ValueW - 1)) begin
              recip <= {quo[ValueW-2:0], fits};
              busy  <= 1'b0;
              done  <= 1'b1;
            end
          end
          OP_DIGIT: begin
            case (cnt)
              StepCntW'(0): prod <= dvd * recip;
              StepCntW'(1): begin
                quo  <= qest;
                part <= PartW'(diff);
              end
              default: begin
                // estimate is at most one low
                if (part >= PartW'(radix)) begin
                  quo  <= quo + 1'b1;
                  part <= part - PartW'(radix);
                end
                busy <= 1'b0;
                done <= 1'b1;
              end
            endcase
          end
          default: busy <= 1'b0;
        endcase
      end
    end
  end

endmodule

// ----- design/sitrt_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: alphabet check, digit loop, digit stack and output register.
module sitrt_ctrl import sitrt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ValueW-1:0]   value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SymbolW-1:0]  symbol,
  output logic                last,
  input  logic                cfg_hit,
  output logic [ByteIdxW-1:0] rd_index,
  input  logic [SymbolW-1:0]  rd_byte,
  output div_req_t            div_req,
  output logic [RadixW-1:0]   div_radix,
  output logic [ValueW-1:0]   div_mag,
  input  div_stat_t           div_stat,
  input  logic [ValueW-1:0]   div_quot,
  input  logic [ByteIdxW-1:0] div_rem
);

  state_t               state;
  state_t               state_next;
  logic                 stale;
  logic                 radix_ok;
  logic [RadixW-1:0]    radix;
  logic [RadixW-1:0]    idx;
  logic [127:0]         seen;
  logic                 neg;
  logic [ValueW-1:0]    mag;
  logic [ByteIdxW-1:0]  digits [ValueW];
  logic [DigitCntW-1:0] nd;
  logic [DigitCntW-1:0] top;
  logic                 accept;
  logic                 scan_end;
  logic                 byte_bad;
  logic                 div_more;
  logic                 out_free;
  logic                 out_load;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign top      = nd - 1'b1;
  assign scan_end = (idx == RadixW'(MaxSymbols)) || (rd_byte == '0);
  assign byte_bad = (rd_byte <= ChSpace) || rd_byte[SymbolW-1] || (rd_byte == ChPlus) ||
                    (rd_byte == ChMinus) || (rd_byte == ChDel) || seen[rd_byte[6:0]];
  assign div_more = (div_quot != '0) && (nd != DigitCntW'(ValueW - 1));
  assign div_radix = radix;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (stale) state_next = ST_SCAN;
          else if (radix_ok) state_next = ST_DIV_GO;
        end
      end
      ST_SCAN: begin
        if (scan_end) state_next = (idx < RadixW'(2)) ? ST_IDLE : ST_RECIP_GO;
        else if (byte_bad) state_next = ST_IDLE;
      end
      ST_RECIP_GO:   state_next = ST_RECIP_WAIT;
      ST_RECIP_WAIT: if (div_stat.done) state_next = ST_DIV_GO;
      ST_DIV_GO:     state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:   if (div_stat.done && !div_more) state_next = ST_SIGN;
      ST_SIGN:       if (!neg || out_free) state_next = ST_EMIT;
      ST_EMIT:       if (out_free && nd == DigitCntW'(1)) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = state != ST_IDLE;
    div_req.start = (state == ST_RECIP_GO) || (state == ST_DIV_GO) ||
                    (state == ST_DIV_WAIT && div_stat.done && div_more);
    div_req.op    = (state == ST_RECIP_GO) ? OP_RECIP : OP_DIGIT;
    div_mag       = (state == ST_DIV_WAIT) ? div_quot : mag;
    rd_index      = (state == ST_EMIT) ? digits[top[DigIdxW-1:0]] : ByteIdxW'(idx);
    out_load      = ((state == ST_SIGN) && neg && out_free) || ((state == ST_EMIT) && out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      stale     <= 1'b1;
      radix_ok  <= 1'b0;
      nd        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_hit) stale <= 1'b1;

      if (accept) begin
        neg  <= value[ValueW-1];
        mag  <= value[ValueW-1] ? ValueW'(0) - value : value;
        nd   <= '0;
        idx  <= '0;
        seen <= '0;
      end

      if (state == ST_SCAN) begin
        if (scan_end || byte_bad) begin
          stale    <= 1'b0;
          radix_ok <= 1'b0;
          radix    <= idx;
        end else begin
          seen[rd_byte[6:0]] <= 1'b1;
          idx <= idx + 1'b1;
        end
      end

      if (state == ST_RECIP_WAIT && div_stat.done) radix_ok <= 1'b1;

      if (state == ST_DIV_WAIT && div_stat.done) begin
        digits[nd[DigIdxW-1:0]] <= div_rem;
        nd <= nd + 1'b1;
      end

      if (state == ST_EMIT && out_free) nd <= top;

      if (out_load) begin
        out_valid <= 1'b1;
        symbol    <= (state == ST_SIGN) ? ChMinus : rd_byte;
        last      <= (state == ST_EMIT) && (nd == DigitCntW'(1));
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_nd_bound: assert property (@(posedge clk) disable iff (rst)
    nd <= DigitCntW'(ValueW))
    else $error("digit count overflow");

  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_RECIP_WAIT || state == ST_DIV_WAIT))
    else $error("divider result not expected");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (nd != '0))
    else $error("emit with empty digit stack");

  a_radix_min: assert property (@(posedge clk) disable iff (rst)
    (radix_ok && !stale) |-> (radix >= RadixW'(2)))
    else $error("radix below two marked valid");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free && nd == DigitCntW'(1)) |=> (state == ST_IDLE && last))
    else $error("final transfer not followed by idle");
`endif

endmodule

// ----- design/signed_int_to_radix_text.sv -----
`timescale 1ns / 1ps
// Per item: the digits come from a shared reciprocal-multiply divider, then are sent out from a stack;
// a minus sign is loaded in the sign state before the digits, and the idle state then takes the next transfer.
// One item at a time; in_stall is high from the transfer in until the last character is loaded.
// After reset or an alphabet write, the next item first runs a check of the alphabet
// (one alphabet byte a cycle) and, for a valid alphabet, a bit-serial radix reciprocal.
// Synchronous active-high reset clears the alphabet; an empty alphabet emits nothing.
module signed_int_to_radix_text import sitrt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ValueW-1:0]   value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SymbolW-1:0]  symbol,
  output logic                last
);

  logic [ByteIdxW-1:0] rd_index;
  logic [SymbolW-1:0]  rd_byte;
  logic                cfg_hit;
  div_req_t            div_req;
  div_stat_t           div_stat;
  logic [RadixW-1:0]   div_radix;
  logic [ValueW-1:0]   div_mag;
  logic [ValueW-1:0]   div_quot;
  logic [ByteIdxW-1:0] div_rem;

  sitrt_alpha u_alpha (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_index  (rd_index),
    .rd_byte   (rd_byte),
    .cfg_hit   (cfg_hit)
  );

  sitrt_divu u_divu (
    .clk   (clk),
    .rst   (rst),
    .req   (div_req),
    .radix (div_radix),
    .mag   (div_mag),
    .stat  (div_stat),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  sitrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol),
    .last      (last),
    .cfg_hit   (cfg_hit),
    .rd_index  (rd_index),
    .rd_byte   (rd_byte),
    .div_req   (div_req),
    .div_radix (div_radix),
    .div_mag   (div_mag),
    .div_stat  (div_stat),
    .div_quot  (div_quot),
    .div_rem   (div_rem)
  );

endmodule
